FILE: hw/rtl/odo_pkg.sv
// Shared types, constants, microprogram and arctangent table of the odometry block.
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int PC_W      = 5;
    localparam int ITER_W    = 5;
    localparam int PROG_LEN  = 25;
    localparam int DIV_STEPS = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BASE    = 2'd2;

    localparam logic [CFG_W-1:0] SCALE_RESET = 24'd537830;
    localparam logic [CFG_W-1:0] INV_RESET   = 24'd3084047;

    localparam logic [15:0] RAD_LO  = 16'h60DC;
    localparam logic [15:0] RAD_HI  = 16'h28BE;
    localparam logic [15:0] GAIN    = 16'h9B75;
    localparam logic [15:0] VEL_LO  = 16'h4240;
    localparam logic [15:0] VEL_HI  = 16'h000F;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [23:0]        elapsed_us;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        yaw;
        logic signed [23:0] lin_vel;
        logic signed [23:0] ang_vel;
    } out_word_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACC_LD, OP_DL, OP_DR, OP_DSUM, OP_DTH, OP_ANG, OP_VSUM,
        OP_CINIT, OP_CSTEP, OP_POSE, OP_DINIT, OP_DSTEP, OP_LVEL, OP_AVEL
    } op_t;

    typedef enum logic [2:0] {
        A_DLC, A_DRC, A_DIFF, A_DTH, A_D, A_DS8
    } a_sel_t;

    typedef enum logic [3:0] {
        B_SL_LO, B_SL_HI, B_SR_LO, B_SR_HI, B_W_LO, B_W_HI,
        B_RAD_LO, B_RAD_HI, B_GAIN, B_VEL_LO, B_VEL_HI
    } b_sel_t;

    typedef struct packed {
        logic   mul_en;
        a_sel_t a_sel;
        b_sel_t b_sel;
        op_t    op;
    } uop_t;

    typedef struct packed {
        logic              capture;
        logic              out_load;
        uop_t              uop;
        logic [ITER_W-1:0] iter;
    } ctl_cmd_t;

    function automatic uop_t mk_uop(input logic m, input a_sel_t a, input b_sel_t b,
                                    input op_t op);
        uop_t u;
        u.mul_en = m;
        u.a_sel  = a;
        u.b_sel  = b;
        u.op     = op;
        return u;
    endfunction

    function automatic uop_t prog(input logic [PC_W-1:0] pc);
        uop_t u;
        u = mk_uop(1'b0, A_DLC, B_SL_LO, OP_NONE);
        unique case (pc)
            5'd0:  u = mk_uop(1'b1, A_DLC,  B_SL_LO,  OP_NONE);
            5'd1:  u = mk_uop(1'b1, A_DLC,  B_SL_HI,  OP_ACC_LD);
            5'd2:  u = mk_uop(1'b1, A_DRC,  B_SR_LO,  OP_DL);
            5'd3:  u = mk_uop(1'b1, A_DRC,  B_SR_HI,  OP_ACC_LD);
            5'd4:  u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_DR);
            5'd5:  u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_DSUM);
            5'd6:  u = mk_uop(1'b1, A_DIFF, B_W_LO,   OP_NONE);
            5'd7:  u = mk_uop(1'b1, A_DIFF, B_W_HI,   OP_ACC_LD);
            5'd8:  u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_DTH);
            5'd9:  u = mk_uop(1'b1, A_DTH,  B_RAD_LO, OP_NONE);
            5'd10: u = mk_uop(1'b1, A_DTH,  B_RAD_HI, OP_ACC_LD);
            5'd11: u = mk_uop(1'b1, A_D,    B_GAIN,   OP_ANG);
            5'd12: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_CINIT);
            5'd13: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_CSTEP);
            5'd14: u = mk_uop(1'b1, A_DS8,  B_VEL_LO, OP_POSE);
            5'd15: u = mk_uop(1'b1, A_DS8,  B_VEL_HI, OP_ACC_LD);
            5'd16: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_VSUM);
            5'd17: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_DINIT);
            5'd18: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_DSTEP);
            5'd19: u = mk_uop(1'b1, A_DTH,  B_VEL_LO, OP_LVEL);
            5'd20: u = mk_uop(1'b1, A_DTH,  B_VEL_HI, OP_ACC_LD);
            5'd21: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_VSUM);
            5'd22: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_DINIT);
            5'd23: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_DSTEP);
            5'd24: u = mk_uop(1'b0, A_DLC,  B_SL_LO,  OP_AVEL);
            default: u = mk_uop(1'b0, A_DLC, B_SL_LO, OP_NONE);
        endcase
        return u;
    endfunction

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/odo_if.sv
// Valid/ready channel interfaces for the odometry input and output words.
`timescale 1ns / 1ps
`default_nettype none
interface odo_in_if;
    logic               valid;
    logic               ready;
    odo_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface odo_out_if;
    logic               valid;
    logic               ready;
    odo_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/odo_ctrl.sv
// Controller state machine that sequences the odometry datapath microprogram.
`timescale 1ns / 1ps
`default_nettype none
module odo_ctrl #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output odo_pkg::ctl_cmd_t cmd
);
    import odo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    localparam logic [ITER_W-1:0] CORD_LAST = ITER_W'(CORDIC_STAGES - 1);
    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);
    localparam logic [PC_W-1:0]   PC_LAST   = PC_W'(PROG_LEN - 1);

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    uop_t              uop;
    logic              is_loop;
    logic [ITER_W-1:0] loop_last;
    logic              in_fire;
    logic              out_load;

    assign uop       = prog(pc_reg);
    assign is_loop   = (uop.op == OP_CSTEP) || (uop.op == OP_DSTEP);
    assign loop_last = (uop.op == OP_CSTEP) ? CORD_LAST : DIV_LAST;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_RUN;
                    pc_next    = '0;
                    cnt_next   = '0;
                end
            end
            S_RUN:
            begin
                if (is_loop && (cnt_reg != loop_last))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                    if (pc_reg == PC_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = in_fire;
        cmd.out_load = out_load;
        cmd.iter     = cnt_reg;
        if (state_reg == S_RUN)
        begin
            cmd.uop = uop;
        end
        else
        begin
            cmd.uop = mk_uop(1'b0, A_DLC, B_SL_LO, OP_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (pc_reg <= PC_LAST))
        else $error("microprogram counter ran past the program");

    a_cord_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && uop.op == OP_CSTEP) |-> (cnt_reg <= CORD_LAST))
        else $error("CORDIC iteration count out of range");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_RUN && pc_reg == '0))
        else $error("accepted word did not start the program");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten before it was taken");

endmodule
`default_nettype wire

FILE: hw/rtl/odo_datapath.sv
// Odometry datapath: shared multiplier, CORDIC rotator, serial divider and pose state.
`timescale 1ns / 1ps
`default_nettype none
module odo_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [odo_pkg::CFG_W-1:0]      cfg_wdata,
    input  odo_pkg::ctl_cmd_t              cmd,
    input  odo_pkg::in_word_t              in_word,
    output odo_pkg::out_word_t             out_word
);
    import odo_pkg::*;

    localparam logic signed [57:0] D_HI    = 58'sd140737488355328;
    localparam logic signed [57:0] D_LO    = -58'sd140737488355328;
    localparam logic signed [57:0] DIFF_HI = 58'sd274877906944;
    localparam logic signed [57:0] DIFF_LO = -58'sd274877906944;
    localparam logic signed [63:0] I32_HI  = 64'sd2147483647;
    localparam logic signed [63:0] I32_LO  = -64'sd2147483648;
    localparam logic [23:0]        V_MAX   = 24'h7FFFFF;
    localparam logic [23:0]        V_MIN   = 24'h800000;

    logic [CFG_W-1:0]   scale_l_reg, scale_r_reg, inv_w_reg;
    logic [31:0]        prev_l_reg, prev_l_next, prev_r_reg, prev_r_next;
    logic [31:0]        acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [31:0]        heading_reg, heading_next;

    logic signed [31:0] dlc_reg, dlc_next, drc_reg, drc_next;
    logic [23:0]        el_reg, el_next;
    logic signed [63:0] prod_reg, prod_next, acc_reg, acc_next;
    logic signed [56:0] dl_reg, dl_next, dr_reg, dr_next;
    logic signed [48:0] d_reg, d_next;
    logic               dnz_reg, dnz_next;
    logic signed [39:0] diff_reg, diff_next;
    logic signed [31:0] dth_reg, dth_next;
    logic [31:0]        dbam_reg, dbam_next;
    logic signed [49:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0]        cz_reg, cz_next;
    logic [23:0]        rem_reg, rem_next, quo_reg, quo_next;
    logic               neg_reg, neg_next, ovf_reg, ovf_next;
    logic [23:0]        lin_reg, lin_next, ang_reg, ang_next;
    out_word_t          out_reg, out_next;

    logic signed [48:0] mul_a;
    logic [15:0]        mul_b;
    logic signed [64:0] mul_full;
    logic signed [63:0] acc_plus;
    logic signed [57:0] dsum, draw, ddif, dsh;
    logic signed [63:0] tsh;
    logic [31:0]        angle;
    logic signed [49:0] xg, xs, ys;
    logic [31:0]        at;
    logic [63:0]        vmag;
    logic [24:0]        rem_sh;
    logic               ge;
    logic [23:0]        vel_res;

    always_comb
    begin
        unique case (cmd.uop.a_sel)
            A_DLC:   mul_a = 49'(dlc_reg);
            A_DRC:   mul_a = 49'(drc_reg);
            A_DIFF:  mul_a = 49'(diff_reg);
            A_DTH:   mul_a = 49'(dth_reg);
            A_D:     mul_a = d_reg;
            A_DS8:   mul_a = d_reg >>> 8;
            default: mul_a = '0;
        endcase
        unique case (cmd.uop.b_sel)
            B_SL_LO:  mul_b = scale_l_reg[15:0];
            B_SL_HI:  mul_b = {8'd0, scale_l_reg[23:16]};
            B_SR_LO:  mul_b = scale_r_reg[15:0];
            B_SR_HI:  mul_b = {8'd0, scale_r_reg[23:16]};
            B_W_LO:   mul_b = inv_w_reg[15:0];
            B_W_HI:   mul_b = {8'd0, inv_w_reg[23:16]};
            B_RAD_LO: mul_b = RAD_LO;
            B_RAD_HI: mul_b = RAD_HI;
            B_GAIN:   mul_b = GAIN;
            B_VEL_LO: mul_b = VEL_LO;
            B_VEL_HI: mul_b = VEL_HI;
            default:  mul_b = '0;
        endcase
    end

    assign mul_full = mul_a * $signed({1'b0, mul_b});
    assign acc_plus = acc_reg + (prod_reg <<< 16);
    assign dsum     = 58'(dl_reg) + 58'(dr_reg);
    assign draw     = dsum >>> 1;
    assign ddif     = 58'(dr_reg) - 58'(dl_reg);
    assign dsh      = ddif >>> 8;
    assign tsh      = acc_plus >>> 20;
    assign angle    = heading_reg - dbam_reg;
    assign xg       = 50'($signed(prod_reg[63:16]));
    assign xs       = cx_reg >>> cmd.iter;
    assign ys       = cy_reg >>> cmd.iter;
    assign at       = atan_bam(cmd.iter);
    assign vmag     = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign rem_sh   = {rem_reg, quo_reg[23]};
    assign ge       = (rem_sh >= {1'b0, el_reg});

    always_comb
    begin
        if (el_reg == '0)
        begin
            vel_res = '0;
        end
        else if (ovf_reg)
        begin
            vel_res = neg_reg ? V_MIN : V_MAX;
        end
        else if (!neg_reg)
        begin
            vel_res = (quo_reg > V_MAX) ? V_MAX : quo_reg;
        end
        else
        begin
            vel_res = (quo_reg > V_MIN) ? V_MIN : 24'(-quo_reg);
        end
    end

    always_comb
    begin
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        heading_next = heading_reg;
        dlc_next     = dlc_reg;
        drc_next     = drc_reg;
        el_next      = el_reg;
        prod_next    = cmd.uop.mul_en ? mul_full[63:0] : prod_reg;
        acc_next     = acc_reg;
        dl_next      = dl_reg;
        dr_next      = dr_reg;
        d_next       = d_reg;
        dnz_next     = dnz_reg;
        diff_next    = diff_reg;
        dth_next     = dth_reg;
        dbam_next    = dbam_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        lin_next     = lin_reg;
        ang_next     = ang_reg;
        out_next     = out_reg;

        if (cmd.capture)
        begin
            dlc_next    = in_word.left_count - $signed(prev_l_reg);
            drc_next    = in_word.right_count - $signed(prev_r_reg);
            el_next     = in_word.elapsed_us;
            prev_l_next = in_word.left_count;
            prev_r_next = in_word.right_count;
        end

        unique case (cmd.uop.op)
            OP_NONE: ;
            OP_ACC_LD: acc_next = prod_reg;
            OP_DL:     dl_next = acc_plus[56:0];
            OP_DR:     dr_next = acc_plus[56:0];
            OP_DSUM:
            begin
                dnz_next = (draw != '0);
                if (draw > D_HI)
                    d_next = D_HI[48:0];
                else if (draw < D_LO)
                    d_next = D_LO[48:0];
                else
                    d_next = draw[48:0];
                if (dsh > DIFF_HI)
                    diff_next = DIFF_HI[39:0];
                else if (dsh < DIFF_LO)
                    diff_next = DIFF_LO[39:0];
                else
                    diff_next = dsh[39:0];
            end
            OP_DTH:
            begin
                if (tsh > I32_HI)
                    dth_next = I32_HI[31:0];
                else if (tsh < I32_LO)
                    dth_next = I32_LO[31:0];
                else
                    dth_next = tsh[31:0];
            end
            OP_ANG:  dbam_next = acc_plus[55:24];
            OP_VSUM: acc_next = acc_plus;
            OP_CINIT:
            begin
                cy_next = '0;
                if (angle[31:30] == 2'b01 || angle[31:30] == 2'b10)
                begin
                    cx_next = -xg;
                    cz_next = angle + 32'h8000_0000;
                end
                else
                begin
                    cx_next = xg;
                    cz_next = angle;
                end
            end
            OP_CSTEP:
            begin
                if (cz_reg[31])
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + at;
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - at;
                end
            end
            OP_POSE:
            begin
                if (dnz_reg)
                begin
                    acc_x_next = acc_x_reg + cx_reg[47:16];
                    acc_y_next = acc_y_reg + cy_reg[47:16];
                end
                heading_next = heading_reg + dbam_reg;
            end
            OP_DINIT:
            begin
                neg_next = acc_reg[63];
                ovf_next = (vmag[63:32] >= {8'd0, el_reg});
                rem_next = vmag[55:32];
                quo_next = vmag[31:8];
            end
            OP_DSTEP:
            begin
                rem_next = ge ? 24'(rem_sh - {1'b0, el_reg}) : rem_sh[23:0];
                quo_next = {quo_reg[22:0], ge};
            end
            OP_LVEL: lin_next = vel_res;
            OP_AVEL: ang_next = vel_res;
            default: ;
        endcase

        if (cmd.out_load)
        begin
            out_next.pos_x   = acc_x_reg;
            out_next.pos_y   = acc_y_reg;
            out_next.yaw     = heading_reg;
            out_next.lin_vel = lin_reg;
            out_next.ang_vel = ang_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_l_reg <= SCALE_RESET;
            scale_r_reg <= SCALE_RESET;
            inv_w_reg   <= INV_RESET;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LEFT_SCALE:  scale_l_reg <= cfg_wdata;
                    CFG_RIGHT_SCALE: scale_r_reg <= cfg_wdata;
                    CFG_INV_BASE:    inv_w_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
            heading_reg <= heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dlc_reg  <= dlc_next;
        drc_reg  <= drc_next;
        el_reg   <= el_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        dl_reg   <= dl_next;
        dr_reg   <= dr_next;
        d_reg    <= d_next;
        dnz_reg  <= dnz_next;
        diff_reg <= diff_next;
        dth_reg  <= dth_next;
        dbam_reg <= dbam_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
        lin_reg  <= lin_next;
        ang_reg  <= ang_next;
        out_reg  <= out_next;
    end

    assign out_word = out_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/diff_drive_odometry_top.sv
// Top level of the differential drive wheel odometry block.
//
// The din channel takes one word per encoder sample: absolute left and right
// counts and the microseconds elapsed since the previous sample. The dout
// channel returns one word per sample: the pose (x, y in Q16.16 metres, yaw as
// a binary angle) and the linear and angular velocities in Q8.16.
// Registers are written through cfg_we, cfg_index and cfg_wdata; the user must
// write them only while the block is idle; the block itself leaves this to the user.
// A write to an unused index is dropped. A word is taken only while the block
// is idle. It then runs a microprogram on one shared 49 by 16 bit multiplier,
// a CORDIC rotator of CORDIC_STAGES steps and a one-bit-per-cycle divider run
// twice for 24 steps each. The output word becomes valid in the same cycle as
// the block turns idle and is ready to take the next word.
// A finished word waits in an output register; if dout stalls, the block
// still takes and processes the next sample and holds its result until the
// register frees up.
// Reset clears the pose, the previous counts and all handshakes, and restores
// the default wheel scales and base width.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_odometry_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [odo_pkg::CFG_W-1:0]     cfg_wdata,
    odo_in_if.sink                        din,
    odo_out_if.source                     dout
);
    import odo_pkg::*;

    ctl_cmd_t cmd;
    logic     in_ready;
    logic     out_valid;

    odo_ctrl #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (in_ready),
        .out_ready(dout.ready),
        .out_valid(out_valid),
        .cmd      (cmd)
    );

    odo_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd),
        .in_word  (din.data),
        .out_word (dout.data)
    );

    assign din.ready  = in_ready;
    assign dout.valid = out_valid;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for diff_drive_odometry_top with a pose and velocity predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import odo_pkg::*;

    class odometry_scoreboard;
        bit [23:0] left_scale, right_scale, inv_base;
        bit [31:0] last_left, last_right, pose_x, pose_y, heading;
        out_word_t pose_q[$];
        int        errors;
        int        results;
        bit [31:0] atan_step[16] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

        function new();
            left_scale = SCALE_RESET;
            right_scale = SCALE_RESET;
            inv_base = INV_RESET;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [23:0] val);
            case (idx)
                CFG_LEFT_SCALE: left_scale = val;
                CFG_RIGHT_SCALE: right_scale = val;
                CFG_INV_BASE: inv_base = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint speed(longint num, bit [23:0] el);
            if (el == 0)
                return 0;
            return clip((num * 1000000) / (longint'(el) * 256), -8388608, 8388607);
        endfunction

        function void note(in_word_t w);
            bit [31:0] dlt, drt, dbam, z;
            longint    dl, dr, draw, travel, diff, dth, x, y, xs, ys;
            out_word_t e;
            dlt = w.left_count - last_left;
            drt = w.right_count - last_right;
            dl = longint'($signed(dlt)) * longint'(left_scale);
            dr = longint'($signed(drt)) * longint'(right_scale);
            draw = (dl + dr) >>> 1;
            travel = clip(draw, -(64'sd1 <<< 47), 64'sd1 <<< 47);
            diff = clip((dr - dl) >>> 8, -(64'sd1 <<< 38), 64'sd1 <<< 38);
            dth = clip((diff * longint'(inv_base)) >>> 20, -64'sd2147483648, 64'sd2147483647);
            dbam = 32'((dth * 683565276) >>> 24);
            if (draw != 0)
            begin
                x = (travel * 39797) >>> 16;
                y = 0;
                z = heading - dbam;
                if (z[31:30] == 2'd1 || z[31:30] == 2'd2)
                begin
                    x = -x;
                    z = z + 32'h80000000;
                end
                for (int i = 0; i < 16; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (z[31])
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + atan_step[i];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - atan_step[i];
                    end
                end
                pose_x = pose_x + 32'(x >>> 16);
                pose_y = pose_y + 32'(y >>> 16);
            end
            heading = heading + dbam;
            last_left = w.left_count;
            last_right = w.right_count;
            e.pos_x = pose_x;
            e.pos_y = pose_y;
            e.yaw = heading;
            e.lin_vel = 24'(speed(travel >>> 8, w.elapsed_us));
            e.ang_vel = 24'(speed(dth, w.elapsed_us));
            pose_q.push_back(e);
        endfunction

        function void check(out_word_t a);
            out_word_t e;
            results++;
            if (pose_q.size() == 0)
            begin
                $error("unexpected output word %h", a);
                errors++;
                return;
            end
            e = pose_q.pop_front();
            if (a.pos_x !== e.pos_x)
            begin
                $error("pos_x expected %h actual %h", e.pos_x, a.pos_x);
                errors++;
            end
            if (a.pos_y !== e.pos_y)
            begin
                $error("pos_y expected %h actual %h", e.pos_y, a.pos_y);
                errors++;
            end
            if (a.yaw !== e.yaw)
            begin
                $error("yaw expected %h actual %h", e.yaw, a.yaw);
                errors++;
            end
            if (a.lin_vel !== e.lin_vel)
            begin
                $error("lin_vel expected %h actual %h", e.lin_vel, a.lin_vel);
                errors++;
            end
            if (a.ang_vel !== e.ang_vel)
            begin
                $error("ang_vel expected %h actual %h", e.ang_vel, a.ang_vel);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    odo_in_if             din();
    odo_out_if            dout();

    diff_drive_odometry_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .din(din.sink), .dout(dout.source)
    );

    odometry_scoreboard sb = new();
    int        idle_mode;
    bit        hold_req;
    int        quiet_cycles;
    int        words_in;
    bit [31:0] sent_left, sent_right;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din.valid && din.ready)
            begin
                sb.note(din.data);
                words_in <= words_in + 1;
            end
            if (dout.valid && dout.ready)
            begin
                sb.check(dout.data);
            end
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000)
            begin
                $display("diff_drive_odometry_top: mismatch");
                $finish;
            end
        end
    end

    // The long hold-off lets the block finish one sample and take the next,
    // so the input side stalls behind the full output register.
    initial
    begin
        dout.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                dout.ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_mode == 2 || idle_mode == 3)
                dout.ready <= ($urandom % 100) >= (idle_mode == 2 ? 66 : 33);
            else
                dout.ready <= 1'b1;
        end
    end

    task automatic send_word(bit [31:0] l, bit [31:0] r, bit [23:0] el);
        int gap;
        gap = 0;
        if (idle_mode == 1 || idle_mode == 3)
            if (($urandom % 100) < (idle_mode == 1 ? 66 : 33))
                gap = $urandom_range(1, 6);
        din.data <= {l, r, el};
        din.valid <= 1'b1;
        sent_left = l;
        sent_right = r;
        do
            @(posedge clk);
        while (!din.ready);
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        din.valid <= 1'b0;
        @(posedge clk);
        while (sb.pose_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word();
        int        pick;
        bit [31:0] l, r;
        bit [23:0] el;
        pick = $urandom % 100;
        if (pick < 70)
        begin
            l = sent_left + 32'($urandom_range(0, 8000)) - 32'd4000;
            r = sent_right + 32'($urandom_range(0, 8000)) - 32'd4000;
        end
        else if (pick < 78)
        begin
            l = sent_left;
            r = sent_right;
        end
        else if (pick < 90)
        begin
            l = $urandom;
            r = $urandom;
        end
        else
        begin
            l = sent_left + 32'($urandom_range(0, 2000)) - 32'd1000;
            r = sent_right + 32'($urandom_range(0, 2000)) - 32'd1000;
            r = $urandom_range(0, 1) ? 2 * sent_left - l : r;
        end
        pick = $urandom % 100;
        if (pick < 6)
            el = 24'd0;
        else if (pick < 12)
            el = 24'hFFFFFF;
        else if (pick < 20)
            el = 24'($urandom_range(1, 100));
        else if (pick < 30)
            el = 24'($urandom);
        else
            el = 24'($urandom_range(1000, 200000));
        send_word(l, r, el);
    endtask

    initial
    begin
        bit [23:0] ls, rs, ib;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LEFT_SCALE;
        cfg_wdata = '0;
        din.valid = 1'b0;
        din.data = '0;
        idle_mode = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        words_in = 0;
        sent_left = 0;
        sent_right = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(32'd0, 32'd0, 24'd1000);
        send_word(32'd100, 32'd100, 24'd0);
        send_word(32'd300, 32'd200, 24'd20000);
        send_word(32'd100, 32'd400, 24'hFFFFFF);
        send_word(32'd100, 32'd400, 24'd1);
        send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 24'd1);
        send_word(32'h80000000, 32'h80000000, 24'd1);
        send_word(32'h7FFFFFFF, 32'h80000000, 24'd1);
        send_word(32'h00000000, 32'hFFFFFFFF, 24'd5);
        send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 24'd1);
        send_word(32'h00001000, 32'hFFFFF000, 24'd50000);
        send_word(32'h00001000, 32'h00003000, 24'd50000);
        send_word(32'h00005000, 32'h00003000, 24'd0);
        drain();
        write_reg(CFG_LEFT_SCALE, 24'hFFFFFF);
        write_reg(CFG_RIGHT_SCALE, 24'hFFFFFF);
        write_reg(CFG_INV_BASE, 24'd0);
        write_reg(CFG_INV_BASE + 2'd1, 24'h123456);
        send_word(32'h80000000, 32'h7FFFFFFF, 24'd1);
        send_word(32'h7FFFFFFF, 32'h80000000, 24'd1);
        send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 24'd0);
        send_word(32'd12345, 32'd12345, 24'd3);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0: begin ls = SCALE_RESET; rs = SCALE_RESET; ib = INV_RESET; end
                1: begin ls = 24'hFFFFFF; rs = 24'hFFFFFF; ib = 24'hFFFFFF; end
                2: begin ls = 24'd0; rs = 24'd0; ib = 24'd1; end
                3: begin ls = 24'd0; rs = 24'($urandom); ib = 24'd0; end
                4: begin ls = 24'($urandom); rs = 24'd0; ib = 24'd1; end
                default:
                begin
                    ls = 24'($urandom);
                    rs = 24'($urandom);
                    ib = 24'($urandom_range(1, 24'hFFFFFF));
                end
            endcase
            write_reg(CFG_LEFT_SCALE, ls);
            write_reg(CFG_RIGHT_SCALE, rs);
            write_reg(CFG_INV_BASE, ib);
            idle_mode = ph % 4;
            for (int n = 0; n < 240; n++)
            begin
                if (ph == 1 && n == 40)
                    hold_req = 1'b1;
                random_word();
            end
        end
        drain();

        $display("Sent %0d samples over eight register settings and four idling patterns;",
                 words_in);
        $display("checked %0d output words including a long output stall.", sb.results);
        if (sb.errors == 0 && sb.pose_q.size() == 0)
            $display("diff_drive_odometry_top: match");
        else
            $display("diff_drive_odometry_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
